[rtl/core/dwc_pkg.sv]
// Shared types, constants and helper functions for the depth word codec.
`timescale 1ns / 1ps

package dwc_pkg;

    localparam int DEPTH_W = 18;
    localparam int WORD_W  = 16;
    localparam int MANT_W  = 11;
    localparam int EXP_W   = 3;
    localparam int HALF_W  = 16;
    localparam int CODE_W  = 4;

    localparam logic [DEPTH_W:0]  DEPTH_FULL     = 19'h40000;
    localparam logic [EXP_W-1:0]  EXP_MAX        = 3'd7;
    localparam logic [EXP_W-1:0]  EXP_NO_SHIFT   = 3'd6;
    localparam logic [WORD_W-1:0] SLOPE_SAT      = 16'h8000;
    localparam logic [CODE_W-1:0] SLOPE_SAT_CODE = 4'd15;
    localparam logic [WORD_W-1:0] SLOPE_ONE      = 16'd1;
    localparam logic [WORD_W-1:0] SLOPE_THREE    = 16'd3;

    typedef enum logic [1:0] {
        MODE_PACK   = 2'd0,
        MODE_UNPACK = 2'd1,
        MODE_SLOPE  = 2'd2
    } mode_t;

    // packed_word ends up in the low bits
    typedef struct packed {
        logic [CODE_W-1:0]  slope_code;
        logic [WORD_W-1:0]  slope_delta;
        logic [1:0]         delta_bits;
        logic [DEPTH_W-1:0] depth_out;
        logic [WORD_W-1:0]  packed_word;
    } result_t;

    // Mantissa shift for an exponent; the two top exponents share shift 0.
    function automatic logic [2:0] mant_shift(input logic [EXP_W-1:0] e);
        return (e < EXP_NO_SHIFT) ? (EXP_NO_SHIFT - e) : 3'd0;
    endfunction

    // Offset of each exponent band within the depth range.
    function automatic logic [DEPTH_W-1:0] unpack_base(input logic [EXP_W-1:0] e);
        logic [DEPTH_W:0] b;
        b = DEPTH_FULL - (DEPTH_FULL >> e);
        return b[DEPTH_W-1:0];
    endfunction

endpackage

[rtl/core/dwc_core.sv]
// Combinational pack, unpack and slope normalization datapath.
`timescale 1ns / 1ps

module dwc_core (
    input  dwc_pkg::mode_t                 mode,
    input  logic [dwc_pkg::DEPTH_W-1:0]    depth,
    input  logic [3:0]                     delta_code,
    input  logic [dwc_pkg::WORD_W-1:0]     stored_word,
    input  logic [dwc_pkg::HALF_W-1:0]     slope_x_hi,
    input  logic [dwc_pkg::HALF_W-1:0]     slope_y_hi,
    output dwc_pkg::result_t               result
);

    logic                             run;
    logic [dwc_pkg::EXP_W-1:0]        p_exp;
    logic [2:0]                       p_shift;
    logic [dwc_pkg::DEPTH_W-1:0]      p_shifted;
    logic [dwc_pkg::WORD_W-1:0]       p_word;
    logic [dwc_pkg::EXP_W-1:0]        u_exp;
    logic [2:0]                       u_shift;
    logic [dwc_pkg::DEPTH_W-1:0]      u_mant;
    logic [dwc_pkg::DEPTH_W-1:0]      u_depth;
    logic [dwc_pkg::HALF_W-2:0]       fold_x;
    logic [dwc_pkg::HALF_W-2:0]       fold_y;
    logic [dwc_pkg::WORD_W-1:0]       s_sum;
    logic [3:0]                       s_pos;
    logic [dwc_pkg::WORD_W-1:0]       s_delta;
    logic [dwc_pkg::CODE_W-1:0]       s_code;

    // pack: exponent is the run of leading ones, at most 7
    always_comb begin
        run   = 1'b1;
        p_exp = '0;
        for (int i = 0; i < int'(dwc_pkg::EXP_MAX); i++) begin
            if (run && depth[dwc_pkg::DEPTH_W-1-i]) begin
                p_exp = p_exp + 3'd1;
            end else begin
                run = 1'b0;
            end
        end
        p_shift   = dwc_pkg::mant_shift(p_exp);
        p_shifted = depth >> p_shift;
        p_word    = {p_exp, p_shifted[dwc_pkg::MANT_W-1:0], delta_code[3:2]};
    end

    // unpack
    always_comb begin
        u_exp   = stored_word[15:13];
        u_shift = dwc_pkg::mant_shift(u_exp);
        u_mant  = {7'd0, stored_word[12:2]};
        u_depth = (u_mant << u_shift) + dwc_pkg::unpack_base(u_exp);
    end

    // slope: fold halves, sum, next power of two above it; 1 gives 3, saturates
    always_comb begin
        fold_x  = slope_x_hi[15] ? ~slope_x_hi[14:0] : slope_x_hi[14:0];
        fold_y  = slope_y_hi[15] ? ~slope_y_hi[14:0] : slope_y_hi[14:0];
        s_sum   = {1'b0, fold_x} + {1'b0, fold_y};
        s_pos   = '0;
        for (int i = 1; i < 14; i++) begin
            if (s_sum[i]) begin
                s_pos = 4'(i);
            end
        end
        if (s_sum[15] || s_sum[14]) begin
            s_delta = dwc_pkg::SLOPE_SAT;
            s_code  = dwc_pkg::SLOPE_SAT_CODE;
        end else if (s_sum == '0) begin
            s_delta = dwc_pkg::SLOPE_ONE;
            s_code  = 4'd0;
        end else if (s_sum == 16'd1) begin
            s_delta = dwc_pkg::SLOPE_THREE;
            s_code  = 4'd1;
        end else begin
            s_delta = dwc_pkg::SLOPE_ONE << (s_pos + 4'd1);
            s_code  = s_pos + 4'd1;
        end
    end

    always_comb begin
        result = '0;
        unique case (mode)
            dwc_pkg::MODE_PACK: begin
                result.packed_word = p_word;
            end
            dwc_pkg::MODE_UNPACK: begin
                result.depth_out  = u_depth;
                result.delta_bits = stored_word[1:0];
            end
            dwc_pkg::MODE_SLOPE: begin
                result.slope_delta = s_delta;
                result.slope_code  = s_code;
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

[rtl/core/depth_word_codec_unit.sv]
// Top level of the depth word codec: input register, datapath, result register.
`timescale 1ns / 1ps

// Converts one transaction per clock: packs an 18-bit depth into a 16-bit
// exponent/mantissa word (tuser = 0), unpacks a stored word to depth and delta
// bits (tuser = 1), or normalizes a depth slope to a power of two and its log2
// (tuser = 2; a sum of one gives 3 and code 1); tuser = 3 gives an all-zero
// result. The input register and the result register sit around a single
// combinational pass. Full throughput of one transaction per cycle is held
// while m_axis_tready stays high; a stalled result holds in the output
// register while one more transaction is taken. Fields the selected mode does
// not produce read as zero.

module depth_word_codec_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // depth[17:0], delta_code[21:18], stored_word[37:22], slope_x[69:38],
    // slope_y[101:70], zero[103:102]
    input  logic [103:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // packed_word[15:0], depth_out[33:16], delta_bits[35:34],
    // slope_delta[51:36], slope_code[55:52]
    output logic [55:0]  m_axis_tdata
);

    logic                              in_valid_reg, in_valid_next;
    dwc_pkg::mode_t                    mode_reg;
    logic [dwc_pkg::DEPTH_W-1:0]       depth_reg;
    logic [3:0]                        delta_code_reg;
    logic [dwc_pkg::WORD_W-1:0]        stored_word_reg;
    logic [dwc_pkg::HALF_W-1:0]        slope_x_hi_reg;
    logic [dwc_pkg::HALF_W-1:0]        slope_y_hi_reg;
    logic                              out_valid_reg, out_valid_next;
    dwc_pkg::result_t                  out_reg;
    dwc_pkg::result_t                  result;
    logic                              s_accept;
    logic                              out_advance;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (out_advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg        <= dwc_pkg::mode_t'(s_axis_tuser);
            depth_reg       <= s_axis_tdata[17:0];
            delta_code_reg  <= s_axis_tdata[21:18];
            stored_word_reg <= s_axis_tdata[37:22];
            slope_x_hi_reg  <= s_axis_tdata[69:54];
            slope_y_hi_reg  <= s_axis_tdata[101:86];
        end
        if (out_advance && in_valid_reg) begin
            out_reg <= result;
        end
    end

    dwc_core u_core (
        .mode        (mode_reg),
        .depth       (depth_reg),
        .delta_code  (delta_code_reg),
        .stored_word (stored_word_reg),
        .slope_x_hi  (slope_x_hi_reg),
        .slope_y_hi  (slope_y_hi_reg),
        .result      (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

[rtl/core/dwc_checker.sv]
// Port-level checker for the depth word codec, bound to the top level.
`timescale 1ns / 1ps

module dwc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_slope_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[51:36] != 16'd0) |->
            ($onehot(m_axis_tdata[51:36]) || m_axis_tdata[51:36] == 16'd3)
            && m_axis_tdata[35:0] == 36'd0)
        else $error("bad slope result");

    a_pack_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[15:0] != 16'd0) |->
            m_axis_tdata[55:16] == 40'd0)
        else $error("pack result mixed with other fields");

    // an idle pipeline always takes a transaction
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && $past(!m_axis_tvalid) && $past(!s_axis_tvalid)
            |-> s_axis_tready)
        else $error("not ready while empty");

endmodule

bind depth_word_codec_unit dwc_checker u_dwc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/depth_word_codec_unit_test.sv]
// Self-checking testbench for depth_word_codec_unit: pack, unpack and slope modes.
`timescale 1ns / 1ps

module depth_word_codec_unit_test;

    localparam logic [1:0] MODE_NONE    = 2'd3;
    localparam int         LATENCY      = 2;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         HOLD_CYCLES  = 300;

    class codec_checker;
        dwc_pkg::result_t pending_results[$];
        int               errors = 0;

        static function int top_bit(input logic [31:0] v);
            int n;
            int i;
            n = 0;
            for (i = 0; i < 32; i++) if (v[i]) n = i;
            return n;
        endfunction

        function logic [15:0] pack_depth(input logic [17:0] depth, input logic [3:0] code);
            logic [17:0] inv;
            logic [10:0] mant;
            int          e;
            int          sh;
            inv = 18'h3ffff - depth;
            if (inv == 0) inv = 18'd1;
            e = 17 - top_bit(inv);
            if (e > 7) e = 7;
            sh = (e < 6) ? 6 - e : 0;
            mant = 11'(depth >> sh);
            return {e[2:0], mant, code[3:2]};
        endfunction

        function logic [17:0] unpack_word(input logic [15:0] w);
            logic [2:0] e;
            int         sh;
            int         d;
            e = w[15:13];
            sh = (e < 6) ? 6 - e : 0;
            d = (int'(w[12:2]) << sh) + (32'h40000 - (32'h40000 >> e));
            return d[17:0];
        endfunction

        // negative halves fold to their ones' complement, 15 bits
        function logic [15:0] fold_half(input logic [31:0] s);
            logic [15:0] h;
            h = s[31:16];
            return h[15] ? {1'b0, ~h[14:0]} : h;
        endfunction

        function dwc_pkg::result_t convert_item(input logic [1:0] m,
                                                input logic [103:0] d);
            dwc_pkg::result_t r;
            logic [15:0]      sum;
            logic [15:0]      sd;
            r = '0;
            case (m)
                dwc_pkg::MODE_PACK: begin
                    r.packed_word = pack_depth(d[17:0], d[21:18]);
                end
                dwc_pkg::MODE_UNPACK: begin
                    r.depth_out  = unpack_word(d[37:22]);
                    r.delta_bits = d[23:22];
                end
                dwc_pkg::MODE_SLOPE: begin
                    sum = fold_half(d[69:38]) + fold_half(d[101:70]);
                    if (sum[15:14] != 2'b00) sd = 16'h8000;
                    else if (sum == 16'd0) sd = 16'd1;
                    else if (sum == 16'd1) sd = 16'd3;
                    else sd = 16'd2 << top_bit(sum);
                    r.slope_delta = sd;
                    r.slope_code  = 4'(top_bit(sd));
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_input(input logic [1:0] m, input logic [103:0] d);
            pending_results.push_back(convert_item(m, d));
        endfunction

        function void check_result(input logic [55:0] bits);
            dwc_pkg::result_t got;
            dwc_pkg::result_t want;
            got = bits;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction %h", bits);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.packed_word != want.packed_word) begin
                $error("packed_word expected %h actual %h", want.packed_word, got.packed_word);
                errors++;
            end
            if (got.depth_out != want.depth_out) begin
                $error("depth_out expected %h actual %h", want.depth_out, got.depth_out);
                errors++;
            end
            if (got.delta_bits != want.delta_bits) begin
                $error("delta_bits expected %h actual %h", want.delta_bits, got.delta_bits);
                errors++;
            end
            if (got.slope_delta != want.slope_delta) begin
                $error("slope_delta expected %h actual %h", want.slope_delta, got.slope_delta);
                errors++;
            end
            if (got.slope_code != want.slope_code) begin
                $error("slope_code expected %h actual %h", want.slope_code, got.slope_code);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // depth[17:0], delta_code[21:18], stored_word[37:22], slope_x[69:38],
    // slope_y[101:70], zero[103:102]
    logic [103:0] s_axis_tdata;
    // mode[1:0]
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // packed_word[15:0], depth_out[33:16], delta_bits[35:34],
    // slope_delta[51:36], slope_code[55:52]
    logic [55:0]  m_axis_tdata;

    logic         quiet;
    logic         hold_request;
    codec_checker board;

    depth_word_codec_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [103:0] make_data(input logic [17:0] depth,
                                               input logic [3:0] code,
                                               input logic [15:0] word,
                                               input logic [31:0] sx,
                                               input logic [31:0] sy);
        return {2'b00, sy, sx, word, code, depth};
    endfunction

    // half the time a small magnitude, so every slope band shows up
    function automatic logic [31:0] rand_slope();
        logic [15:0] mag;
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(1)) begin
            mag = 16'($urandom & ((16'd1 << $urandom_range(14)) - 16'd1));
            v[31:16] = $urandom_range(1) ? ~mag : mag;
        end
        return v;
    endfunction

    task automatic send_item(input logic [1:0] m, input logic [103:0] d);
        while (!quiet && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= m;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_input(m, d);
    endtask

    task automatic send_random();
        logic [1:0]  m;
        logic [17:0] depth;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 32) m = dwc_pkg::MODE_PACK;
        else if (pick < 64) m = dwc_pkg::MODE_UNPACK;
        else if (pick < 97) m = dwc_pkg::MODE_SLOPE;
        else m = MODE_NONE;
        depth = 18'($urandom);
        if ($urandom_range(2) != 0)
            depth = 18'(18'h3ffff - ($urandom & ((18'd1 << $urandom_range(17)) - 18'd1)));
        send_item(m, make_data(depth, 4'($urandom), 16'($urandom), rand_slope(),
                               rand_slope()));
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request <= 1'b0;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int i;
        board = new();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= dwc_pkg::MODE_PACK;
        quiet         <= 1'b0;
        hold_request  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pack: depth extremes, full depth, some exponent band edges
        send_item(dwc_pkg::MODE_PACK, make_data(18'h00000, 4'h0, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h3ffff, 4'hf, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h3fffe, 4'h4, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h1ffff, 4'h8, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h20000, 4'hc, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h3f000, 4'h3, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h3f800, 4'hb, '0, '0, '0));
        send_item(dwc_pkg::MODE_PACK, make_data(18'h3ff80, 4'h7, '0, '0, '0));
        // unpack: word extremes, top exponents
        send_item(dwc_pkg::MODE_UNPACK, make_data('0, '0, 16'h0000, '0, '0));
        send_item(dwc_pkg::MODE_UNPACK, make_data('0, '0, 16'hffff, '0, '0));
        send_item(dwc_pkg::MODE_UNPACK, make_data('0, '0, 16'hc000, '0, '0));
        send_item(dwc_pkg::MODE_UNPACK, make_data('0, '0, 16'he001, '0, '0));
        send_item(dwc_pkg::MODE_UNPACK, make_data('0, '0, 16'h1fff, '0, '0));
        send_item(dwc_pkg::MODE_UNPACK, make_data('0, '0, 16'h5556, '0, '0));
        // slope: zero sum, sum of one, saturation, negative halves, band edges
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h0000ffff, 32'h00000000));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h00010000, 32'h00000000));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h7fff0000, 32'h7fffffff));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h80000000, 32'h00000000));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'hffff0000, 32'hffffffff));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h00020000, 32'hfffe1234));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h1fff0000, 32'h00010000));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h20000000, 32'h1fff0000));
        send_item(dwc_pkg::MODE_SLOPE, make_data('0, '0, '0, 32'h3fff0000, 32'h00000000));
        send_item(MODE_NONE, make_data('1, '1, '1, '1, '1));

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100) hold_request <= 1'b1;
            if (i == 400) quiet <= 1'b1;
            if (i == 550) quiet <= 1'b0;
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 6) @(posedge aclk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
